// ===== rtl/vpid_pkg.sv =====
`default_nettype none

package vpid_pkg;

    localparam int GainW   = 10;
    localparam int MagW    = 15;
    localparam int VelW    = 16;
    localparam int ErrW    = VelW + 1;
    localparam int DiffW   = ErrW + 1;
    localparam int SumW    = 32;
    localparam int CfgIdxW = 3;

    // Product and accumulation widths for the three gain terms.
    localparam int PropW   = GainW + 1 + ErrW;
    localparam int IntW    = GainW + 1 + SumW;
    localparam int DerW    = GainW + 1 + DiffW;
    localparam int AccW    = IntW + 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_P_GAIN   = 3'd0,
        REG_I_GAIN   = 3'd1,
        REG_D_GAIN   = 3'd2,
        REG_FRICTION = 3'd3,
        REG_VEL_LIM  = 3'd4
    } t_cfg_idx;

    localparam logic [GainW-1:0]       RstPGain    = 10'd128;
    localparam logic [GainW-1:0]       RstIGain    = 10'd2;
    localparam logic [GainW-1:0]       RstDGain    = 10'd0;
    localparam logic [MagW-1:0]        RstFriction = 15'd200;
    localparam logic [MagW-1:0]        RstVelLimit = 15'd20;
    localparam logic signed [VelW-1:0] RstTarget   = 16'sd10;

endpackage

`default_nettype wire

// ===== rtl/velocity_pid_with_friction_offset.sv =====
`default_nettype none

// Channel     Dir  Handshake                        Payload
// s_axis      in   i_s_axis_tvalid/o_s_axis_tready  tdata: new_target, measured_velocity
//                                                   tuser: new_target_valid
// m_axis      out  o_m_axis_tvalid/i_m_axis_tready  tdata: drive
// cfg         in   i_cfg_wr_en                      i_cfg_index, i_cfg_data
//
// Four-stage pipeline: input register, error and integrator update, gain
// products, sum/friction/saturation into the output register.
// One beat is accepted every cycle while the output is not stalled; a beat
// passes registers A, B, C and D before o_m_axis_tvalid. The integrator and
// target update in stage two closes the only loop, on the edge that loads B.
// A stalled output fills the stages back to the input, then drops tready.
// Synchronous active-low reset restores the register and loop state.

module velocity_pid_with_friction_offset
    import vpid_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [15:0] new_target, [31:16] measured_velocity
    input  wire logic [2*VelW-1:0]    i_s_axis_tdata,
    // [0] new_target_valid
    input  wire logic [0:0]           i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [15:0] drive
    output logic [VelW-1:0]           o_m_axis_tdata,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [MagW-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [GainW-1:0] r_p_gain, r_i_gain, r_d_gain;
    logic [MagW-1:0]  r_friction, r_vel_limit;

    // Loop state.
    logic signed [VelW-1:0] r_target;
    logic signed [SumW-1:0] r_esum;
    logic signed [ErrW-1:0] r_last_err;

    // Stage A: input register.
    logic                   r_a_v, r_a_newv;
    logic signed [VelW-1:0] r_a_target, r_a_meas;

    // Stage B: error terms.
    logic                    r_b_v, r_b_zero;
    logic signed [ErrW-1:0]  r_b_err;
    logic signed [SumW-1:0]  r_b_esum;
    logic signed [DiffW-1:0] r_b_diff;

    // Stage C: products.
    logic                   r_c_v, r_c_zero;
    logic signed [PropW-1:0] r_c_pe;
    logic signed [IntW-1:0]  r_c_ie;
    logic signed [DerW-1:0]  r_c_de;

    // Stage D: output register.
    logic                   r_d_v;
    logic [VelW-1:0]        r_d_data;

    logic a_ready, b_ready, c_ready, d_ready;
    logic a_go, b_go, c_go, in_go;

    assign d_ready = !r_d_v || i_m_axis_tready;
    assign c_ready = !r_c_v || d_ready;
    assign b_ready = !r_b_v || c_ready;
    assign a_ready = !r_a_v || b_ready;
    assign in_go   = i_s_axis_tvalid && a_ready;
    assign a_go    = r_a_v && b_ready;
    assign b_go    = r_b_v && c_ready;
    assign c_go    = r_c_v && d_ready;

    assign o_s_axis_tready = a_ready;
    assign o_m_axis_tvalid = r_d_v;
    assign o_m_axis_tdata  = r_d_data;

    // Stage A to B: target select, clamp, error, error difference and saturating integrator.
    logic signed [VelW-1:0]  t_sel, t_clamp;
    logic                    t_zero;
    logic signed [ErrW-1:0]  t_ext, lim_ext, nlim_ext, err;
    logic signed [SumW:0]    esum_wide;
    logic signed [SumW-1:0]  n_esum;
    logic signed [DiffW-1:0] diff;

    always_comb begin
        t_sel    = r_a_newv ? r_a_target : r_target;
        t_zero   = (t_sel == '0);
        t_ext    = ErrW'(t_sel);
        lim_ext  = $signed(ErrW'(r_vel_limit));
        nlim_ext = -lim_ext;
        if (t_ext > lim_ext) begin
            t_clamp = lim_ext[VelW-1:0];
        end else if (t_ext < nlim_ext) begin
            t_clamp = nlim_ext[VelW-1:0];
        end else begin
            t_clamp = t_sel;
        end
        err       = ErrW'(t_clamp) - ErrW'(r_a_meas);
        esum_wide = (SumW+1)'(r_esum) + (SumW+1)'(err);
        if (esum_wide[SumW] != esum_wide[SumW-1]) begin
            n_esum = esum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                     : {1'b0, {(SumW-1){1'b1}}};
        end else begin
            n_esum = esum_wide[SumW-1:0];
        end
        diff = DiffW'(err) - DiffW'(r_last_err);
    end

    // Stage C to D: PID sum, friction offset and drive saturation.
    logic signed [AccW-1:0] sum_pid, sum_fr, fr_ext;
    logic signed [VelW-1:0] drive_sat;

    always_comb begin
        sum_pid = AccW'(r_c_pe) + AccW'(r_c_ie) + AccW'(r_c_de);
        fr_ext  = $signed(AccW'(r_friction));
        sum_fr  = (sum_pid > AccW'(0)) ? sum_pid + fr_ext : sum_pid - fr_ext;
        if (sum_fr > AccW'(32767)) begin
            drive_sat = 16'sh7FFF;
        end else if (sum_fr < -AccW'(32768)) begin
            drive_sat = 16'sh8000;
        end else begin
            drive_sat = sum_fr[VelW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain    <= RstPGain;
            r_i_gain    <= RstIGain;
            r_d_gain    <= RstDGain;
            r_friction  <= RstFriction;
            r_vel_limit <= RstVelLimit;
            r_target    <= RstTarget;
            r_esum      <= '0;
            r_last_err  <= '0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_d_v       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_P_GAIN:   r_p_gain    <= i_cfg_data[GainW-1:0];
                    REG_I_GAIN:   r_i_gain    <= i_cfg_data[GainW-1:0];
                    REG_D_GAIN:   r_d_gain    <= i_cfg_data[GainW-1:0];
                    REG_FRICTION: r_friction  <= i_cfg_data;
                    REG_VEL_LIM:  r_vel_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (a_go) begin
                if (t_zero) begin
                    r_target <= t_sel;
                end else begin
                    r_target   <= t_clamp;
                    r_esum     <= n_esum;
                    r_last_err <= err;
                end
            end
            if (a_ready) r_a_v <= i_s_axis_tvalid;
            if (b_ready) r_b_v <= r_a_v;
            if (c_ready) r_c_v <= r_b_v;
            if (d_ready) r_d_v <= r_c_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_a_newv   <= i_s_axis_tuser[0];
            r_a_target <= $signed(i_s_axis_tdata[VelW-1:0]);
            r_a_meas   <= $signed(i_s_axis_tdata[2*VelW-1:VelW]);
        end
        if (a_go) begin
            r_b_zero <= t_zero;
            r_b_err  <= err;
            r_b_esum <= n_esum;
            r_b_diff <= diff;
        end
        if (b_go) begin
            r_c_zero <= r_b_zero;
            r_c_pe   <= $signed({1'b0, r_p_gain}) * r_b_err;
            r_c_ie   <= $signed({1'b0, r_i_gain}) * r_b_esum;
            r_c_de   <= $signed({1'b0, r_d_gain}) * r_b_diff;
        end
        if (c_go) begin
            r_d_data <= r_c_zero ? '0 : drive_sat;
        end
    end

    // A zero-target beat must leave the drive at zero.
    a_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_go && r_c_zero) |=> (o_m_axis_tdata == '0))
        else $error("zero target did not give zero drive");

    // A zero-target beat must not disturb the integrator or the last error.
    a_zero_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && t_zero) |=> ($stable(r_esum) && $stable(r_last_err)))
        else $error("loop state changed on a zero target");

    // After a live beat the stored target lies within the limit.
    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && !t_zero && !i_cfg_wr_en) |=>
        (ErrW'(r_target) <= lim_ext && ErrW'(r_target) >= nlim_ext))
        else $error("stored target outside the velocity limit");

    // Input backpressure only comes from a full pipeline.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_a_v && r_b_v && r_c_v && r_d_v))
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire
